/* hw/rtl/ppdp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pen packet decoder.
// No dependencies; used by ppdp_div and the top level.
package ppdp_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 16;  // raw coordinates and window registers
  localparam int unsigned Q_W      = 12;  // scaled coordinate, quotient bits
  localparam int unsigned NUM_W    = COORD_W + Q_W;
  localparam int unsigned CNT_W    = $clog2(Q_W);
  localparam int unsigned POS_X_W  = 12;
  localparam int unsigned POS_Y_W  = 11;
  localparam int unsigned PRESS_W  = 12;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ID_W     = 4;

  // Panel spans; each must stay below 2**Q_W so the quotient fits Q_W bits
  localparam logic [Q_W-1:0] PANEL_X_SPAN = Q_W'(2560);
  localparam logic [Q_W-1:0] PANEL_Y_SPAN = Q_W'(1600);

  // Head byte layout
  localparam int unsigned HB_READY_BIT  = 7;
  localparam int unsigned HB_ERASER_BIT = 6;
  localparam int unsigned HB_SIDE_BIT   = 5;
  localparam int unsigned HB_TIP_BIT    = 4;
  localparam logic [ID_W-1:0] ID_COORD  = ID_W'(1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_X_LO    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_X_HI    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_Y_LO    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_Y_HI    = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_X_EXT   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SILENCE = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SUPP_EN = IDX_W'(6);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PEN  = 2'd1,
    KIND_REL  = 2'd2
  } kind_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [COORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/pen_packet_decoder_with_proximity.sv */
`timescale 1ns / 1ps
// Pen packet decoder with proximity tracking: top level, sequencer and state.
// Depends on ppdp_pkg and ppdp_div.

// One input beat is either a coordinate packet or a millisecond tick, and every
// input beat yields exactly one output beat. A complete packet with id 1 and the
// ready bit set gives a pen report (kind 1) with clamped, scaled coordinates; a
// packet with the ready bit clear, or the silence counter expiring on ticks,
// gives one release report (kind 2) if the pen was in range; anything else gives
// kind 0 with all fields zero except suppress_touch. A tick, an ignored packet
// or a release packet goes from idle straight to the done state, where its
// result loads once the output register is free. A pen report runs, per axis,
// through a clamp state, a multiply state, a divider start and a wait on the
// shared one-bit-per-cycle divider until it flags done after its 12 quotient
// bits; the divider serves x then y, and the done state loads the result.
// An axis whose calibration window is empty skips the multiply and divide.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register, so the next beat may be accepted while it waits for
// out_ready. Configuration writes are registered and must only happen while
// the block is idle.
module pen_packet_decoder_with_proximity (
  input  logic                              clk,
  input  logic                              rst_n,

  // configuration write port
  input  logic                              cfg_we,
  input  logic [ppdp_pkg::IDX_W-1:0]        cfg_index,
  input  logic [ppdp_pkg::COORD_W-1:0]      cfg_wdata,

  // input beats
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic                              in_read_complete,
  input  logic [7:0]                        in_head_byte,
  input  logic [ppdp_pkg::COORD_W-1:0]      in_raw_first,
  input  logic [ppdp_pkg::COORD_W-1:0]      in_raw_second,
  input  logic [7:0]                        in_press_high,
  input  logic [7:0]                        in_press_low,
  input  logic [7:0]                        in_hover_dist,
  input  logic signed [7:0]                 in_tilt_in_x,
  input  logic signed [7:0]                 in_tilt_in_y,

  // result beats
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_report_kind,
  output logic                              out_tool_eraser,
  output logic                              out_tool_pen,
  output logic                              out_tip_down,
  output logic                              out_side_button,
  output logic [ppdp_pkg::POS_X_W-1:0]      out_pos_x,
  output logic [ppdp_pkg::POS_Y_W-1:0]      out_pos_y,
  output logic [ppdp_pkg::PRESS_W-1:0]      out_pressure,
  output logic [7:0]                        out_distance,
  output logic signed [7:0]                 out_tilt_out_x,
  output logic signed [7:0]                 out_tilt_out_y,
  output logic                              out_suppress_touch
);

  localparam int unsigned CW = ppdp_pkg::COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,   // clamp to window, subtract low edge
    ST_MUL,     // offset times panel span
    ST_DSTART,  // hand product to the divider
    ST_DWAIT,   // wait for quotient
    ST_DONE     // update proximity state, load result
  } state_t;

  state_t state_r;

  // ---------------- configuration registers ----------------
  logic [CW-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r, x_ext_r, silence_r;
  logic          supp_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r    <= CW'(0);
      x_hi_r    <= CW'(23575);
      y_lo_r    <= CW'(0);
      y_hi_r    <= CW'(14724);
      x_ext_r   <= CW'(14752);
      silence_r <= CW'(250);
      supp_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ppdp_pkg::REG_X_LO:    x_lo_r    <= cfg_wdata;
        ppdp_pkg::REG_X_HI:    x_hi_r    <= cfg_wdata;
        ppdp_pkg::REG_Y_LO:    y_lo_r    <= cfg_wdata;
        ppdp_pkg::REG_Y_HI:    y_hi_r    <= cfg_wdata;
        ppdp_pkg::REG_X_EXT:   x_ext_r   <= cfg_wdata;
        ppdp_pkg::REG_SILENCE: silence_r <= cfg_wdata;
        ppdp_pkg::REG_SUPP_EN: supp_en_r <= cfg_wdata[0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- latched beat ----------------
  logic                          action_r;
  logic                          complete_r;
  logic [7:0]                    head_r;
  logic [CW-1:0]                 vx_r;       // x source: raw second axis
  logic signed [CW:0]            vy_r;       // y source: extent minus raw first
  logic [ppdp_pkg::PRESS_W-1:0]  press_r;
  logic [7:0]                    dist_r;
  logic signed [7:0]             tilt_x_r, tilt_y_r;

  // proximity state
  logic          in_range_r, armed_r;
  logic [CW-1:0] ticks_r;

  // axis work registers
  logic                          axis_r;     // 0 = x, 1 = y
  logic [CW-1:0]                 off_r;
  logic [ppdp_pkg::NUM_W-1:0]    prod_r;
  logic [ppdp_pkg::POS_X_W-1:0]  pos_x_r;
  logic [ppdp_pkg::POS_Y_W-1:0]  pos_y_r;

  // output registers
  logic                          out_valid_r;
  ppdp_pkg::kind_t               kind_r;
  logic                          eraser_r, pen_r, tip_r, side_r;
  logic [ppdp_pkg::POS_X_W-1:0]  opos_x_r;
  logic [ppdp_pkg::POS_Y_W-1:0]  opos_y_r;
  logic [ppdp_pkg::PRESS_W-1:0]  opress_r;
  logic [7:0]                    odist_r;
  logic signed [7:0]             otilt_x_r, otilt_y_r;
  logic                          osupp_r;

  // ---------------- handshake ----------------
  logic in_acc;
  logic pen_pkt;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pen_pkt  = !in_action && in_read_complete
                    && (in_head_byte[ppdp_pkg::ID_W-1:0] == ppdp_pkg::ID_COORD)
                    && in_head_byte[ppdp_pkg::HB_READY_BIT];

  // ---------------- clamp and scale datapath ----------------
  logic [CW-1:0]           lo_sel, hi_sel;
  logic signed [CW:0]      v_sel, lo_s, hi_s;
  logic [CW-1:0]           clamped;
  logic                    win_empty;
  logic [ppdp_pkg::Q_W-1:0] span_sel;
  logic [ppdp_pkg::NUM_W-1:0] prod_c;

  assign lo_sel    = axis_r ? y_lo_r : x_lo_r;
  assign hi_sel    = axis_r ? y_hi_r : x_hi_r;
  assign v_sel     = axis_r ? vy_r : $signed({1'b0, vx_r});
  assign lo_s      = $signed({1'b0, lo_sel});
  assign hi_s      = $signed({1'b0, hi_sel});
  assign win_empty = (hi_sel <= lo_sel);
  assign span_sel  = axis_r ? ppdp_pkg::PANEL_Y_SPAN : ppdp_pkg::PANEL_X_SPAN;
  assign prod_c    = ppdp_pkg::NUM_W'(off_r) * ppdp_pkg::NUM_W'(span_sel);

  always_comb begin
    priority if (v_sel < lo_s) begin
      clamped = lo_sel;
    end else if (v_sel > hi_s) begin
      clamped = hi_sel;
    end else begin
      clamped = v_sel[CW-1:0];
    end
  end

  // divider shared by both axes
  ppdp_pkg::div_req_t div_req;
  ppdp_pkg::div_rsp_t div_rsp;

  assign div_req.start = (state_r == ST_DSTART);
  assign div_req.num   = prod_r;
  assign div_req.den   = hi_sel - lo_sel;

  ppdp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- step outcome ----------------
  ppdp_pkg::kind_t kind_c;
  logic            in_range_nxt, armed_nxt;
  logic [CW-1:0]   ticks_nxt;

  always_comb begin
    kind_c       = ppdp_pkg::KIND_NONE;
    in_range_nxt = in_range_r;
    armed_nxt    = armed_r;
    ticks_nxt    = ticks_r;
    if (action_r) begin
      if (armed_r) begin
        if (ticks_r <= CW'(1)) begin
          // silence ran out
          armed_nxt    = 1'b0;
          ticks_nxt    = '0;
          in_range_nxt = 1'b0;
          if (in_range_r) kind_c = ppdp_pkg::KIND_REL;
        end else begin
          ticks_nxt = ticks_r - CW'(1);
        end
      end
    end else if (complete_r && head_r[ppdp_pkg::ID_W-1:0] == ppdp_pkg::ID_COORD) begin
      if (!head_r[ppdp_pkg::HB_READY_BIT]) begin
        // pen lifted out of range
        armed_nxt    = 1'b0;
        ticks_nxt    = '0;
        in_range_nxt = 1'b0;
        if (in_range_r) kind_c = ppdp_pkg::KIND_REL;
      end else begin
        kind_c       = ppdp_pkg::KIND_PEN;
        in_range_nxt = 1'b1;
        armed_nxt    = 1'b1;
        ticks_nxt    = silence_r;
      end
    end
  end

  logic is_pen_c;
  assign is_pen_c = (kind_c == ppdp_pkg::KIND_PEN);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_range_r  <= 1'b0;
      armed_r     <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      // ST_DONE owns out_valid_r in its own cycle
      if (out_valid_r && out_ready && (state_r != ST_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            action_r   <= in_action;
            complete_r <= in_read_complete;
            head_r     <= in_head_byte;
            vx_r       <= in_raw_second;
            vy_r       <= $signed({1'b0, x_ext_r}) - $signed({1'b0, in_raw_first});
            press_r    <= {in_press_high[3:0], in_press_low};
            dist_r     <= in_hover_dist;
            tilt_x_r   <= in_tilt_in_x;
            tilt_y_r   <= in_tilt_in_y;
            axis_r     <= 1'b0;
            state_r    <= pen_pkt ? ST_CLAMP : ST_DONE;
          end
        end

        ST_CLAMP: begin
          off_r <= clamped - lo_sel;
          if (win_empty) begin
            // empty window: coordinate is zero, no divide
            if (axis_r) begin
              pos_y_r <= '0;
              state_r <= ST_DONE;
            end else begin
              pos_x_r <= '0;
              axis_r  <= 1'b1;
            end
          end else begin
            state_r <= ST_MUL;
          end
        end

        ST_MUL: begin
          prod_r  <= prod_c;
          state_r <= ST_DSTART;
        end

        ST_DSTART: begin
          state_r <= ST_DWAIT;
        end

        ST_DWAIT: begin
          if (div_rsp.done) begin
            if (axis_r) begin
              pos_y_r <= div_rsp.quot[ppdp_pkg::POS_Y_W-1:0];
              state_r <= ST_DONE;
            end else begin
              pos_x_r <= div_rsp.quot[ppdp_pkg::POS_X_W-1:0];
              axis_r  <= 1'b1;
              state_r <= ST_CLAMP;
            end
          end
        end

        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            in_range_r  <= in_range_nxt;
            armed_r     <= armed_nxt;
            ticks_r     <= ticks_nxt;
            out_valid_r <= 1'b1;
            kind_r      <= kind_c;
            eraser_r    <= is_pen_c &&  head_r[ppdp_pkg::HB_ERASER_BIT];
            pen_r       <= is_pen_c && !head_r[ppdp_pkg::HB_ERASER_BIT];
            tip_r       <= is_pen_c &&  head_r[ppdp_pkg::HB_TIP_BIT];
            side_r      <= is_pen_c &&  head_r[ppdp_pkg::HB_SIDE_BIT];
            opos_x_r    <= is_pen_c ? pos_x_r  : '0;
            opos_y_r    <= is_pen_c ? pos_y_r  : '0;
            opress_r    <= is_pen_c ? press_r  : '0;
            odist_r     <= is_pen_c ? dist_r   : '0;
            otilt_x_r   <= is_pen_c ? tilt_x_r : '0;
            otilt_y_r   <= is_pen_c ? tilt_y_r : '0;
            osupp_r     <= supp_en_r && in_range_nxt;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_kind    = kind_r;
  assign out_tool_eraser    = eraser_r;
  assign out_tool_pen       = pen_r;
  assign out_tip_down       = tip_r;
  assign out_side_button    = side_r;
  assign out_pos_x          = opos_x_r;
  assign out_pos_y          = opos_y_r;
  assign out_pressure       = opress_r;
  assign out_distance       = odist_r;
  assign out_tilt_out_x     = otilt_x_r;
  assign out_tilt_out_y     = otilt_y_r;
  assign out_suppress_touch = osupp_r;

`ifndef SYNTHESIS
  // pen in range always has a live silence timer
  a_range_armed: assert property (@(posedge clk) disable iff (!rst_n)
    in_range_r |-> armed_r)
    else $error("in range without armed timer");

  // a disarmed timer holds no count
  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (ticks_r == '0))
    else $error("disarmed timer with nonzero count");

  // divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DWAIT))
    else $error("divider done outside wait state");

  // a release report never asks to suppress touch
  a_rel_no_supp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == ppdp_pkg::KIND_REL) |-> !osupp_r)
    else $error("release report with suppress set");
`endif

endmodule

/* hw/rtl/ppdp_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ppdp_pkg. Caller guarantees num < den * 2**Q_W and den != 0.
module ppdp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ppdp_pkg::div_req_t  req,
  output ppdp_pkg::div_rsp_t  rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [ppdp_pkg::CNT_W-1:0]        cnt_r;
  logic [ppdp_pkg::COORD_W-1:0]      rem_r;
  logic [ppdp_pkg::COORD_W-1:0]      den_r;
  logic [ppdp_pkg::Q_W-1:0]          low_r;
  logic [ppdp_pkg::Q_W-1:0]          quot_r;

  logic [ppdp_pkg::COORD_W:0]        trial;
  logic                              ge;
  logic [ppdp_pkg::COORD_W:0]        diff;

  assign trial = {rem_r, low_r[ppdp_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ppdp_pkg::CNT_W'(ppdp_pkg::Q_W - 1);
        rem_r  <= req.num[ppdp_pkg::NUM_W-1:ppdp_pkg::Q_W];
        low_r  <= req.num[ppdp_pkg::Q_W-1:0];
        den_r  <= req.den;
      end else if (busy_r) begin
        // remainder stays below den, so the difference fits COORD_W bits
        rem_r  <= ge ? diff[ppdp_pkg::COORD_W-1:0] : trial[ppdp_pkg::COORD_W-1:0];
        low_r  <= {low_r[ppdp_pkg::Q_W-2:0], 1'b0};
        quot_r <= {quot_r[ppdp_pkg::Q_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
